// ----- sv/lphs_pkg.sv -----
// Shared constants, codes and types of the linear probing hash set.
package lphs_pkg;

  // Table geometry and field widths.
  localparam int CAPACITY  = 32;
  localparam int KEY_BITS  = 64;
  localparam int HASH_BITS = 32;
  localparam int SLOT_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int CMD_W     = 3;
  localparam int STAT_W    = 2;
  localparam int LIMIT_W   = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(24);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_LOOKUP        = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT        = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT_UNIQUE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE        = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR         = 3'd4;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DUP  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd3;

  // One stored slot: hash and key side by side.
  typedef struct packed {
    logic [HASH_BITS-1:0] hash;
    logic [KEY_BITS-1:0]  key;
  } entry_t;

  // Write request into the slot memory.
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    entry_t            data;
  } ram_wr_t;

  // Finished result handed to the output register.
  typedef struct packed {
    logic              valid;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  used;
  } res_t;

endpackage

// ----- sv/lphs_slot_ram.sv -----
// Slot memory holding the stored hash and key of every slot.
module lphs_slot_ram
  import lphs_pkg::*;
(
  input  logic              clk,
  input  ram_wr_t           wr,
  input  logic [SLOT_W-1:0] raddr,
  output entry_t            rdata
);

  entry_t mem [CAPACITY];

  // One write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // One registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/lphs_ctrl.sv -----
// Probe sequencer: walks the slots, keeps the slot flags and applies each command.
module lphs_ctrl
  import lphs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     cmd,
  input  logic [HASH_BITS-1:0] probe_hash,
  input  logic [KEY_BITS-1:0]  key_value,
  input  logic [LIMIT_W-1:0]   load_limit,
  input  logic                 out_free,
  output logic [SLOT_W-1:0]    ram_raddr,
  input  entry_t               ram_rdata,
  output ram_wr_t              ram_wr,
  output res_t                 res
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PROBE = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CAPACITY - 1);

  state_t               state;
  logic [CMD_W-1:0]     cmd_q;
  logic [HASH_BITS-1:0] hash_q;
  logic [KEY_BITS-1:0]  key_q;
  logic [SLOT_W-1:0]    chk_pos;
  logic [SLOT_W-1:0]    n_cnt;
  logic                 tomb_v;
  logic [SLOT_W-1:0]    tomb_idx;
  logic                 hit_v;
  logic [SLOT_W-1:0]    hit_idx;
  logic [CAPACITY-1:0]  live;
  logic [CAPACITY-1:0]  used;
  logic [CNT_W-1:0]     used_total;
  logic [CNT_W-1:0]     used_total_next;

  logic                 accept;
  logic [SLOT_W-1:0]    next_pos;
  logic                 cur_live;
  logic                 cur_used;
  logic                 cur_match;
  logic                 cur_fresh;
  logic                 cur_tomb;
  logic                 hit_live;
  logic                 hit_used;
  logic                 apply_fire;

  logic [STAT_W-1:0]    apply_status;
  logic                 apply_write;
  logic                 apply_live_set;
  logic                 apply_used_set;
  logic                 apply_live_clr;
  logic                 apply_clear;
  logic                 apply_grow;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Slot under test this cycle and its successor with wrap.
  assign next_pos  = (chk_pos == LAST_SLOT) ? '0 : chk_pos + SLOT_W'(1);
  assign cur_live  = live[chk_pos];
  assign cur_used  = used[chk_pos];
  assign cur_match = cur_live && (ram_rdata.hash == hash_q) && (ram_rdata.key == key_q);
  assign cur_fresh = !cur_live && !cur_used;
  assign cur_tomb  = !cur_live && cur_used;

  // The first slot is read as the item is accepted; each probe cycle reads the next one.
  assign ram_raddr = (state == S_IDLE) ? probe_hash[SLOT_W-1:0] : next_pos;

  assign hit_live   = live[hit_idx];
  assign hit_used   = used[hit_idx];
  assign apply_fire = (state == S_APPLY) && out_free;

  // Decide the outcome of the command at the slot the probe ended on.
  always_comb begin
    apply_status   = STAT_MISS;
    apply_write    = 1'b0;
    apply_live_set = 1'b0;
    apply_used_set = 1'b0;
    apply_live_clr = 1'b0;
    apply_clear    = 1'b0;
    apply_grow     = 1'b0;
    unique case (cmd_q) inside
      CMD_LOOKUP: begin
        apply_status = (hit_v && hit_live) ? STAT_DONE : STAT_MISS;
      end
      CMD_INSERT, CMD_INSERT_UNIQUE: begin
        if (!hit_v) begin
          apply_status = STAT_FULL;
        end else if (hit_live) begin
          if (cmd_q == CMD_INSERT_UNIQUE) begin
            apply_status = STAT_DUP;
          end else begin
            apply_write  = 1'b1;
            apply_status = STAT_DONE;
          end
        end else if (hit_used) begin
          apply_write    = 1'b1;
          apply_live_set = 1'b1;
          apply_status   = STAT_DONE;
        end else if (used_total >= CNT_W'(load_limit)) begin
          apply_status = STAT_FULL;
        end else begin
          apply_write    = 1'b1;
          apply_live_set = 1'b1;
          apply_used_set = 1'b1;
          apply_grow     = 1'b1;
          apply_status   = STAT_DONE;
        end
      end
      CMD_REMOVE: begin
        if (hit_v && hit_live) begin
          apply_live_clr = 1'b1;
          apply_status   = STAT_DONE;
        end
      end
      CMD_CLEAR: begin
        apply_clear  = 1'b1;
        apply_status = STAT_DONE;
      end
      default: begin
        apply_status = STAT_MISS;
      end
    endcase
  end

  // Used count after this command.
  always_comb begin
    used_total_next = used_total;
    if (apply_clear) begin
      used_total_next = '0;
    end else if (apply_grow) begin
      used_total_next = used_total + CNT_W'(1);
    end
  end

  // Memory write and result.
  assign ram_wr.en     = apply_fire && apply_write;
  assign ram_wr.addr   = hit_idx;
  assign ram_wr.data   = '{hash: hash_q, key: key_q};
  assign res.valid     = apply_fire;
  assign res.status    = apply_status;
  assign res.used      = used_total_next;

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd) inside
              CMD_LOOKUP, CMD_INSERT, CMD_INSERT_UNIQUE, CMD_REMOVE: state <= S_PROBE;
              default: state <= S_APPLY;
            endcase
          end
        end
        S_PROBE: begin
          if (cur_fresh || cur_match || (n_cnt == LAST_SLOT)) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Item capture and probe bookkeeping.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= cmd;
      hash_q  <= probe_hash;
      key_q   <= key_value;
      chk_pos <= probe_hash[SLOT_W-1:0];
      n_cnt   <= '0;
      tomb_v  <= 1'b0;
    end else if (state == S_PROBE) begin
      if (cur_fresh) begin
        hit_v   <= 1'b1;
        hit_idx <= tomb_v ? tomb_idx : chk_pos;
      end else if (cur_match) begin
        hit_v   <= 1'b1;
        hit_idx <= chk_pos;
      end else begin
        if (cur_tomb && !tomb_v) begin
          tomb_v   <= 1'b1;
          tomb_idx <= chk_pos;
        end
        if (n_cnt == LAST_SLOT) begin
          hit_v   <= tomb_v || cur_tomb;
          hit_idx <= tomb_v ? tomb_idx : chk_pos;
        end else begin
          chk_pos <= next_pos;
          n_cnt   <= n_cnt + SLOT_W'(1);
        end
      end
    end
  end

  // Slot flags and used count.
  always_ff @(posedge clk) begin
    if (rst) begin
      live       <= '0;
      used       <= '0;
      used_total <= '0;
    end else if (apply_fire) begin
      used_total <= used_total_next;
      if (apply_clear) begin
        live <= '0;
        used <= '0;
      end else begin
        if (apply_live_set) begin
          live[hit_idx] <= 1'b1;
        end
        if (apply_live_clr) begin
          live[hit_idx] <= 1'b0;
        end
        if (apply_used_set) begin
          used[hit_idx] <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- sv/linear_probe_hash_set.sv -----
// Top level of the linear probing hash set: config register, output register and checks.
//
// Input channel (in_valid/in_ready) carries one command beat: cmd, probe_hash, key_value.
// Output channel (out_valid/out_ready) returns one beat per command: status, used_count.
// The user is to write the load limit through cfg_wr_en/cfg_wr_data only while the block
// is idle; the block itself does not enforce this. Sequence: the accept cycle issues the
// read of the first slot, each following cycle checks one slot and reads the next, and
// the apply state then applies the command. A command probes from 1 to 32 slots; clear
// and unknown commands skip the probe. Clear resets all slot flags in its apply step.
// The probe walk over the slot memory, one slot per read, sets the rate; one command is
// in flight at a time.
// The output register parts the channels: in_ready returns once a result is handed
// to it, so a new command is taken while the previous result still waits. If the
// receiver stalls, the finished command holds in its apply cycle and in_ready stays
// low until the output register frees up.
// Reset empties the table, zeroes the used count and sets the load limit to 24.
module linear_probe_hash_set
  import lphs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     cmd,
  input  logic [HASH_BITS-1:0] probe_hash,
  input  logic [KEY_BITS-1:0]  key_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STAT_W-1:0]    status,
  output logic [CNT_W-1:0]     used_count,
  input  logic                 cfg_wr_en,
  input  logic [LIMIT_W-1:0]   cfg_wr_data
);

  logic [LIMIT_W-1:0] load_limit;
  logic               out_free;
  logic [SLOT_W-1:0]  ram_raddr;
  entry_t             ram_rdata;
  ram_wr_t            ram_wr;
  res_t               res;

  // Load limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      load_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      load_limit <= cfg_wr_data;
    end
  end

  assign out_free = !out_valid || out_ready;

  lphs_slot_ram u_ram (
    .clk   (clk),
    .wr    (ram_wr),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lphs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .probe_hash (probe_hash),
    .key_value  (key_value),
    .load_limit (load_limit),
    .out_free   (out_free),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .ram_wr     (ram_wr),
    .res        (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      status     <= res.status;
      used_count <= res.used;
    end
  end

  // A result is never handed over while the output register holds an untaken beat.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> out_free)
    else $error("result handed over while output register is occupied");

  // The sequencer never finishes a command in the cycle it takes a new one.
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !res.valid)
    else $error("result produced while accepting input");

  // An accepted command closes the input channel on the next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second command accepted while one is in flight");

  // The used count never exceeds the table size.
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.used <= CNT_W'(CAPACITY)))
    else $error("used count beyond capacity");

endmodule

// ----- tb/lphs_checker.sv -----
// Watches both channels of the hash set, predicts every result and compares it beat by beat.
module lphs_checker
  import lphs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [CMD_W-1:0]     cmd,
  input  logic [HASH_BITS-1:0] probe_hash,
  input  logic [KEY_BITS-1:0]  key_value,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [STAT_W-1:0]    status,
  input  logic [CNT_W-1:0]     used_count,
  input  logic                 cfg_wr_en,
  input  logic [LIMIT_W-1:0]   cfg_wr_data,
  output int                   errors,
  output int                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  used;
  } outcome_t;

  // Shadow copy of the table and the load limit; reset clears them at the first edge.
  logic [KEY_BITS-1:0]  bin_key  [CAPACITY];
  logic [HASH_BITS-1:0] bin_hash [CAPACITY];
  logic                 bin_live [CAPACITY];
  logic                 bin_taken[CAPACITY];
  int                   taken_total;
  logic [LIMIT_W-1:0]   limit_reg;

  outcome_t results_due[$];
  int       fail_tally = 0;

  // Marks every bin as never used.
  function automatic void empty_table();
    for (int i = 0; i < CAPACITY; i++) begin
      bin_live[i]  = 1'b0;
      bin_taken[i] = 1'b0;
    end
    taken_total = 0;
  endfunction

  // Linear probe from the home bin; CAPACITY means the probe found no bin.
  function automatic int find_bin(logic [HASH_BITS-1:0] h, logic [KEY_BITS-1:0] k);
    int pos;
    int tomb;
    pos  = int'(h % CAPACITY);
    tomb = CAPACITY;
    for (int n = 0; n < CAPACITY; n++) begin
      if (!bin_live[pos]) begin
        if (!bin_taken[pos]) return (tomb != CAPACITY) ? tomb : pos;
        if (tomb == CAPACITY) tomb = pos;
      end else if (bin_hash[pos] == h && bin_key[pos] == k) begin
        return pos;
      end
      pos = (pos + 1 == CAPACITY) ? 0 : pos + 1;
    end
    return tomb;
  endfunction

  // Applies one command to the shadow table and returns the expected beat.
  function automatic outcome_t run_command(logic [CMD_W-1:0] c, logic [HASH_BITS-1:0] h,
                                           logic [KEY_BITS-1:0] k);
    outcome_t o;
    int       s;
    o.status = STAT_MISS;
    case (c)
      CMD_LOOKUP: begin
        s = find_bin(h, k);
        if (s < CAPACITY) begin
          if (bin_live[s]) o.status = STAT_DONE;
        end
      end
      CMD_INSERT, CMD_INSERT_UNIQUE: begin
        s = find_bin(h, k);
        if (s >= CAPACITY) begin
          o.status = STAT_FULL;
        end else if (bin_live[s]) begin
          if (c == CMD_INSERT_UNIQUE) begin
            o.status = STAT_DUP;
          end else begin
            bin_key[s]  = k;
            bin_hash[s] = h;
            o.status    = STAT_DONE;
          end
        end else if (bin_taken[s]) begin
          // A tombstone is reused without looking at the load limit.
          bin_key[s]  = k;
          bin_hash[s] = h;
          bin_live[s] = 1'b1;
          o.status    = STAT_DONE;
        end else if (taken_total + 1 > int'(limit_reg)) begin
          o.status = STAT_FULL;
        end else begin
          bin_key[s]   = k;
          bin_hash[s]  = h;
          bin_live[s]  = 1'b1;
          bin_taken[s] = 1'b1;
          taken_total++;
          o.status = STAT_DONE;
        end
      end
      CMD_REMOVE: begin
        s = find_bin(h, k);
        if (s < CAPACITY) begin
          if (bin_live[s]) begin
            bin_live[s] = 1'b0;
            o.status    = STAT_DONE;
          end
        end
      end
      CMD_CLEAR: begin
        empty_table();
        o.status = STAT_DONE;
      end
      default: ;
    endcase
    o.used = CNT_W'(taken_total);
    return o;
  endfunction

  // Sample every channel at the clock edge, compare results, then queue new predictions.
  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst) begin
      empty_table();
      limit_reg = LIMIT_RESET;
      results_due.delete();
    end else begin
      if (cfg_wr_en) limit_reg = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: result beat with nothing expected, got status %0d used %0d",
                   $time, status, used_count);
          fail_tally++;
        end else begin
          want = results_due.pop_front();
          if (status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, status);
            fail_tally++;
          end
          if (used_count !== want.used) begin
            $display("%0t: used_count mismatch, expected %0d, got %0d",
                     $time, want.used, used_count);
            fail_tally++;
          end
        end
      end
      if (in_valid && in_ready) results_due.push_back(run_command(cmd, probe_hash, key_value));
    end
    errors      <= fail_tally;
    outstanding <= results_due.size();
  end

endmodule

// ----- tb/linear_probe_hash_set_tb.sv -----
// Stimulus, handshake pacing and verdict for the linear probing hash set.
module linear_probe_hash_set_tb
  import lphs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL = 40;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 205;
  localparam int HOLD_AT_BEAT = 500;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = CMD_CLEAR + 3'd1;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     cmd = CMD_LOOKUP;
  logic [HASH_BITS-1:0] probe_hash = '0;
  logic [KEY_BITS-1:0]  key_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STAT_W-1:0]    status;
  logic [CNT_W-1:0]     used_count;
  logic                 cfg_wr_en = 1'b0;
  logic [LIMIT_W-1:0]   cfg_wr_data = '0;

  int errors;
  int outstanding;
  int tx_mode = 0;
  int rx_mode = 0;

  logic [HASH_BITS-1:0] pool_hash[POOL];
  logic [KEY_BITS-1:0]  pool_key [POOL];

  linear_probe_hash_set dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .probe_hash (probe_hash),
    .key_value  (key_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .used_count (used_count),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  lphs_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .probe_hash (probe_hash),
    .key_value  (key_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .used_count (used_count),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .errors     (errors),
    .outstanding(outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("linear_probe_hash_set_tb failed");
    $finish;
  end

  // Idle cycles before one beat: none, full range, or mostly none.
  function automatic int pick_gap(int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 16);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
    endcase
  endfunction

  // Offers one command beat and returns at the edge that accepts it.
  task automatic send_beat(input logic [CMD_W-1:0] c, input logic [HASH_BITS-1:0] h,
                           input logic [KEY_BITS-1:0] k);
    int gap;
    gap = pick_gap(tx_mode);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    probe_hash <= h;
    key_value  <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stops offering and waits until every result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // New key pool: half the hashes crowd four home bins, some share a hash with a neighbor.
  task automatic refresh_pool();
    for (int i = 0; i < POOL; i++) begin
      pool_hash[i] = $urandom();
      pool_key[i]  = {$urandom(), $urandom()};
      if (i % 2 == 1) pool_hash[i][SLOT_W-1:0] = SLOT_W'($urandom_range(0, 3));
      if (i % 5 == 4) pool_hash[i] = pool_hash[i-1];
    end
  endtask

  // One random command, mostly on pooled keys so that hits, duplicates and tombstones occur.
  task automatic send_random();
    int                   roll;
    int                   pick;
    logic [CMD_W-1:0]     c;
    logic [HASH_BITS-1:0] h;
    logic [KEY_BITS-1:0]  k;
    roll = $urandom_range(0, 99);
    if (roll < 25) c = CMD_LOOKUP;
    else if (roll < 52) c = CMD_INSERT;
    else if (roll < 67) c = CMD_INSERT_UNIQUE;
    else if (roll < 94) c = CMD_REMOVE;
    else if (roll < 96) c = CMD_CLEAR;
    else c = CMD_UNKNOWN_LO + CMD_W'($urandom_range(0, 2));
    pick = $urandom_range(0, POOL - 1);
    h = pool_hash[pick];
    k = pool_key[pick];
    roll = $urandom_range(0, 99);
    if (roll < 6) k = {$urandom(), $urandom()};
    else if (roll < 10) h = $urandom();
    else if (roll < 14) begin
      h = $urandom();
      k = {$urandom(), $urandom()};
    end
    send_beat(c, h, k);
  endtask

  // Receiver: random stalls per beat, plus one long hold-off that backs up the block.
  initial begin : receiver
    int gap;
    int rx_beats;
    rx_beats = 0;
    while (rst) @(posedge clk);
    forever begin
      if (rx_beats % 50 == 0) rx_mode = $urandom_range(0, 2);
      gap = (rx_beats == HOLD_AT_BEAT) ? HOLD_CYCLES : pick_gap(rx_mode);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      rx_beats++;
    end
  end

  // Stimulus: directed corner cases, then random phases under different load limits.
  initial begin : stimulus
    logic [HASH_BITS-1:0] ones_h;
    logic [KEY_BITS-1:0]  ones_k;
    logic [KEY_BITS-1:0]  other_k;
    logic [LIMIT_W-1:0]   phase_limit[PHASES];
    ones_h  = '1;
    ones_k  = '1;
    other_k = {$urandom(), $urandom()};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A small limit lets the directed part reach a full table quickly.
    tx_mode = 2;
    write_limit(LIMIT_W'(3));
    send_beat(CMD_LOOKUP, ones_h, ones_k);         // empty table misses
    send_beat(CMD_REMOVE, ones_h, ones_k);
    send_beat(CMD_INSERT, ones_h, ones_k);         // lands in the last bin
    send_beat(CMD_INSERT_UNIQUE, ones_h, ones_k);  // duplicate
    send_beat(CMD_INSERT, ones_h, ones_k);         // rewrite of a live match
    send_beat(CMD_LOOKUP, ones_h, ones_k);
    send_beat(CMD_INSERT_UNIQUE, ones_h, '0);      // same hash, probe wraps to bin 0
    send_beat(CMD_INSERT, '0, '0);                 // home bin taken, goes one further
    send_beat(CMD_INSERT, 32'd1, other_k);         // needs a fresh bin over the limit
    send_beat(CMD_REMOVE, ones_h, ones_k);         // leaves a tombstone
    send_beat(CMD_LOOKUP, ones_h, ones_k);
    send_beat(CMD_LOOKUP, ones_h, '0);             // probe passes the tombstone
    send_beat(CMD_INSERT, ones_h, other_k);        // reuses the tombstone at the limit
    send_beat(CMD_REMOVE, ones_h, '0);
    send_beat(CMD_INSERT_UNIQUE, ones_h, ones_k);  // reuses the tombstone after a wrap
    send_beat(CMD_LOOKUP, 32'h20, '0);             // same key, different hash misses
    send_beat(CMD_UNKNOWN_LO, ones_h, ones_k);
    send_beat(CMD_UNKNOWN_LO + 3'd1, '0, '0);
    send_beat(CMD_UNKNOWN_LO + 3'd2, ones_h, other_k);
    send_beat(CMD_CLEAR, ones_h, ones_k);
    send_beat(CMD_LOOKUP, ones_h, '0);
    drain_results();

    // A zero limit turns every fresh insert away.
    write_limit('0);
    send_beat(CMD_INSERT, ones_h, ones_k);
    send_beat(CMD_INSERT_UNIQUE, '0, '0);
    drain_results();
    write_limit(LIMIT_W'(1));
    send_beat(CMD_INSERT, '0, '0);
    send_beat(CMD_INSERT, ones_h, ones_k);
    drain_results();

    phase_limit[0] = LIMIT_W'(31);
    phase_limit[1] = LIMIT_W'(1);
    phase_limit[2] = LIMIT_W'($urandom_range(2, 30));
    phase_limit[3] = LIMIT_RESET;
    phase_limit[4] = LIMIT_W'(31);
    phase_limit[5] = LIMIT_W'($urandom_range(1, 31));
    for (int p = 0; p < PHASES; p++) begin
      write_limit(phase_limit[p]);
      refresh_pool();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) tx_mode = $urandom_range(0, 2);
        send_random();
      end
      drain_results();
    end

    if (errors == 0) begin
      $display("linear_probe_hash_set_tb passed");
    end else begin
      $display("linear_probe_hash_set_tb failed");
    end
    $finish;
  end

endmodule
